FILE: design/xcpd_pkg.sv
// ============================================================================
// xcpd_pkg
// Shared types and constants of the packet deframer with pairing.
// ============================================================================
package xcpd_pkg;

    // Framing bytes and check seed
    localparam logic [7:0]  PREAMBLE_BYTE = 8'hAA;
    localparam logic [7:0]  SYNC_BYTE     = 8'hAB;
    localparam logic [7:0]  CHECK_SEED    = 8'hCC;
    localparam logic [15:0] PAIR_MAGIC    = 16'hABCD;

    // Command codes
    localparam logic [7:0] CMD_PAIR  = 8'h6D;  // 'm'
    localparam logic [7:0] CMD_COLOR = 8'h63;  // 'c'
    localparam logic [7:0] CMD_KEY   = 8'h6B;  // 'k'

    // Receiver phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SYNC  = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    // Input kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_OWN_KEY       = 2'd0;
    localparam logic [1:0] REG_FRAME_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_PING_TIMEOUT  = 2'd2;

    // Register reset values
    localparam logic [15:0] FRAME_TIMEOUT_RST = 16'd200;
    localparam logic [15:0] PING_TIMEOUT_RST  = 16'd2000;

    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_WIDTH   = 24;

    // Classified item passed from front to back
    typedef struct packed {
        logic       tick;
        logic       is_preamble;
        logic       is_sync;
        logic [7:0] data;
    } item_t;

    // One result item
    typedef struct packed {
        logic        frame_good;
        logic        locked;
        logic        master_role;
        logic        paired;
        logic [15:0] color_value;
        logic        color_strobe;
    } result_t;

endpackage

FILE: design/xcpd_front.sv
// ============================================================================
// xcpd_front
// Accepts input transfers, classifies ticks and framing bytes, pushes
// the classified item into the queue.
// ============================================================================
module xcpd_front (
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [7:0]     s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]     s_axis_tuser,   // [0] op
    input  logic           q_full,
    output logic           q_push,
    output xcpd_pkg::item_t q_item
);
    import xcpd_pkg::*;

    // Accept whenever the queue has room
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // Classify the item
    always_comb
    begin
        q_item.tick        = (s_axis_tuser[0] == OP_TICK);
        q_item.is_preamble = (s_axis_tdata == PREAMBLE_BYTE);
        q_item.is_sync     = (s_axis_tdata == SYNC_BYTE);
        q_item.data        = s_axis_tdata;
    end

endmodule

FILE: design/xcpd_queue.sv
// ============================================================================
// xcpd_queue
// Two-entry queue between the front and the back.
// ============================================================================
module xcpd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  xcpd_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output xcpd_pkg::item_t head
);
    import xcpd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    item_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    count_reg,  count_next;

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: design/xcpd_back.sv
// ============================================================================
// xcpd_back
// Runs the frame receiver, timers and pairing state on each queued item
// and holds the result in the output register.
// ============================================================================
module xcpd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  xcpd_pkg::item_t    q_head,
    output logic               q_pop,
    input  logic [15:0]        own_key,
    input  logic [15:0]        frame_timeout,
    input  logic [15:0]        ping_timeout,
    output logic               res_valid,
    input  logic               res_ready,
    output xcpd_pkg::result_t  res
);
    import xcpd_pkg::*;

    logic [1:0]  phase_reg,   phase_next;
    logic [1:0]  index_reg,   index_next;
    logic [7:0]  check_reg,   check_next;
    logic [7:0]  cmd_reg,     cmd_next;
    logic [15:0] data_reg,    data_next;
    logic [15:0] ptimer_reg,  ptimer_next;
    logic [15:0] ping_reg,    ping_next;
    logic        paired_reg,  paired_next;
    logic        master_reg,  master_next;
    logic        locked_reg,  locked_next;
    logic        valid_reg,   valid_next;
    result_t     res_reg,     res_next;
    logic        strobe;
    logic        good;
    logic [15:0] color;
    logic [1:0]  index_inc;
    logic [15:0] key_sum;

    // Take an item when the output register is free or being drained
    assign q_pop     = q_not_empty && (!valid_reg || res_ready);
    assign res_valid = valid_reg;
    assign res       = res_reg;
    assign index_inc = index_reg + 1'b1;
    assign key_sum   = own_key + data_reg;

    // Receiver and pairing update
    always_comb
    begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        check_next  = check_reg;
        cmd_next    = cmd_reg;
        data_next   = data_reg;
        ptimer_next = ptimer_reg;
        ping_next   = ping_reg;
        paired_next = paired_reg;
        master_next = master_reg;
        locked_next = locked_reg;
        strobe      = 1'b0;
        good        = 1'b0;
        color       = '0;

        if (q_head.tick)
        begin
            // Count ticks, saturating; drop stale pairing and frames
            if (ptimer_reg != 16'hFFFF)
            begin
                ptimer_next = ptimer_reg + 1'b1;
            end
            if (ping_reg != 16'hFFFF)
            begin
                ping_next = ping_reg + 1'b1;
            end
            if (paired_reg && (ping_next >= ping_timeout))
            begin
                paired_next = 1'b0;
            end
            if ((phase_reg != PH_IDLE) && (ptimer_next >= frame_timeout))
            begin
                phase_next = PH_IDLE;
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (q_head.is_preamble)
                    begin
                        phase_next  = PH_SYNC;
                        ptimer_next = '0;
                    end
                end
                PH_SYNC:
                begin
                    if (q_head.is_sync)
                    begin
                        phase_next  = PH_DATA;
                        ptimer_next = '0;
                        index_next  = '0;
                        check_next  = CHECK_SEED;
                    end
                end
                PH_DATA:
                begin
                    if (index_reg == 2'd0)
                    begin
                        cmd_next = q_head.data;
                    end
                    else if (index_reg == 2'd1)
                    begin
                        data_next = {data_reg[15:8], q_head.data};
                    end
                    else
                    begin
                        data_next = {q_head.data, data_reg[7:0]};
                    end
                    check_next = check_reg ^ q_head.data;
                    index_next = index_inc;
                    if (index_inc == 2'd3)
                    begin
                        phase_next  = PH_CHECK;
                        ptimer_next = '0;
                    end
                end
                default:
                begin
                    // Check byte: act on a matching frame, then go idle
                    if (check_reg == q_head.data)
                    begin
                        good = 1'b1;
                        case (cmd_reg)
                            CMD_PAIR:
                            begin
                                if (data_reg == PAIR_MAGIC)
                                begin
                                    paired_next = 1'b1;
                                    master_next = 1'b0;
                                end
                            end
                            CMD_COLOR:
                            begin
                                if (paired_reg && !master_reg)
                                begin
                                    strobe      = 1'b1;
                                    color       = data_reg;
                                    locked_next = 1'b1;
                                end
                            end
                            CMD_KEY:
                            begin
                                paired_next = 1'b1;
                                master_next = 1'b1;
                                strobe      = 1'b1;
                                color       = key_sum;
                                locked_next = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                        ping_next = '0;
                    end
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // Form the result
        res_next.color_strobe = strobe;
        res_next.color_value  = color;
        res_next.paired       = paired_next;
        res_next.master_role  = master_next;
        res_next.locked       = locked_next;
        res_next.frame_good   = good;

        valid_next = q_pop ? 1'b1 : (valid_reg && !res_ready);
    end

    // State registers; receiver state is updated only when an item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            index_reg  <= '0;
            check_reg  <= CHECK_SEED;
            cmd_reg    <= '0;
            data_reg   <= '0;
            ptimer_reg <= '0;
            ping_reg   <= '0;
            paired_reg <= 1'b0;
            master_reg <= 1'b0;
            locked_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (q_pop)
            begin
                phase_reg  <= phase_next;
                index_reg  <= index_next;
                check_reg  <= check_next;
                cmd_reg    <= cmd_next;
                data_reg   <= data_next;
                ptimer_reg <= ptimer_next;
                ping_reg   <= ping_next;
                paired_reg <= paired_next;
                master_reg <= master_next;
                locked_reg <= locked_next;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: design/xor_checked_packet_deframer_pairing.sv
// ============================================================================
// xor_checked_packet_deframer_pairing
// Preamble/sync packet receiver with XOR check byte and link pairing.
// ============================================================================
// Usage:
//   The input stream carries one item per transfer: tuser[0] selects a
//   received byte (0) or one timer tick (1); tdata holds the byte.
//   Every input transfer yields exactly one output transfer carrying the
//   color strobe and value, pairing, role and lock flags, and a good-frame
//   flag, in input order.
//   One item is taken per cycle while the output register is free or being
//   drained: the front stage classifies into a two-entry queue and the back
//   stage does the full state update on each item it takes, holding the
//   result in an output register.
//   When the receiver stalls, the result holds in the output register and
//   the queue absorbs up to two more items before tready drops.
//   Reset clears the receiver to waiting for preamble, both timers to zero,
//   all flags, and loads the registers to own key 0, frame timeout 200 and
//   ping timeout 2000 ticks. Registers are written through cfg_we, cfg_addr
//   and cfg_wdata by the user while the block is idle; this is not enforced.
// ============================================================================
module xor_checked_packet_deframer_pairing (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] color_strobe, [16:1] color_value,
                                        // [17] paired, [18] master_role,
                                        // [19] locked, [20] frame_good, [23:21] 0
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import xcpd_pkg::*;

    logic        q_full;
    logic        q_push;
    item_t       q_item;
    logic        q_pop;
    logic        q_not_empty;
    item_t       q_head;
    result_t     res;
    logic [15:0] own_key_reg;
    logic [15:0] frame_timeout_reg;
    logic [15:0] ping_timeout_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_key_reg       <= '0;
            frame_timeout_reg <= FRAME_TIMEOUT_RST;
            ping_timeout_reg  <= PING_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_OWN_KEY:       own_key_reg       <= cfg_wdata;
                REG_FRAME_TIMEOUT: frame_timeout_reg <= cfg_wdata;
                REG_PING_TIMEOUT:  ping_timeout_reg  <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    xcpd_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_item)
    );

    xcpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    xcpd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .own_key       (own_key_reg),
        .frame_timeout (frame_timeout_reg),
        .ping_timeout  (ping_timeout_reg),
        .res_valid     (m_axis_tvalid),
        .res_ready     (m_axis_tready),
        .res           (res)
    );

    // Pack the result, zero fill to whole bytes
    assign m_axis_tdata = {(OUT_WIDTH - $bits(result_t))'(0), res};

`ifndef SYNTHESIS
    // A color is shown only with a good frame
    a_strobe_good: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[20])
        else $error("color strobe without good frame");

    // Showing a color always locks
    a_strobe_lock: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[19] && m_axis_tdata[17])
        else $error("color strobe without lock or pairing");

    // No color value without strobe
    a_color_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[16:1] == 16'h0000))
        else $error("color value set without strobe");

    // Queue full only when the output register is holding a result
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result held");
`endif

endmodule
